// ===== sv/serial_bank_switch_mapper_unit_defines.svh =====
// Assertion macros used by the mapper RTL
`ifndef SERIAL_BANK_SWITCH_MAPPER_UNIT_DEFINES_SVH
`define SERIAL_BANK_SWITCH_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define SBSM_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define SBSM_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbsm_pkg.sv =====
`default_nettype none

package sbsm_pkg;

  // Bus command codes
  localparam logic [1:0] CMD_CPU_READ  = 2'd0;
  localparam logic [1:0] CMD_CPU_WRITE = 2'd1;
  localparam logic [1:0] CMD_PPU       = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_ROM_SIZE_LOG2 = 2'd0;
  localparam logic [1:0] CFG_CHR_IS_RAM        = 2'd1;
  localparam logic [1:0] CFG_HEADER_VERTICAL   = 2'd2;

  // Shift count at which the next serial bit loads the target register
  localparam logic [2:0] SHIFT_LAST = 3'd4;

  // Target memory of a translated access
  typedef enum logic [2:0] {
    REGION_NONE      = 3'd0,
    REGION_PRG_ROM   = 3'd1,
    REGION_PRG_RAM   = 3'd2,
    REGION_CHR       = 3'd3,
    REGION_NAMETABLE = 3'd4,
    REGION_PALETTE   = 3'd5
  } region_t;

  // Bank registers loaded through the serial port
  typedef struct packed {
    logic [4:0] control_word;  // [4] CHR mode, [3:2] PRG mode, [1:0] mirroring
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [3:0] prg_bank;
  } bank_regs_t;

  // Translation of one access
  typedef struct packed {
    region_t     region;
    logic [17:0] mapped_address;
    logic        write_allowed;
  } xlate_result_t;

endpackage

`default_nettype wire

// ===== sv/serial_bank_switch_mapper_unit.sv =====
`default_nettype none

// Serial-load bank-switch mapper. Each accepted transaction (CPU read, CPU
// write or PPU access) is held in an input register, translated and
// serially decoded combinationally, and presented from a result register
// (two register stages from the input pins) that holds it while out_stall
// is high. One transaction can be accepted every cycle while the output is
// not stalled; while a result waits, the input register can take one more.
// CPU writes at 0x8000 and above shift data bit 0 into a five-bit shifter
// (bit 7 clears it); the fifth bit loads the register picked by address
// bits 14:13. A transaction is translated with the banks as they were
// before its own write. Configuration must be written by the user through
// cfg_write/cfg_index/cfg_data only while the mapper is idle; not enforced.
module serial_bank_switch_mapper_unit #(
  parameter int PRG_RAM_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [2:0]  cfg_data,
  // access channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       region,
  output logic [17:0]      mapped_address,
  output logic             write_allowed,
  output logic             register_loaded
);

  `include "serial_bank_switch_mapper_unit_defines.svh"

  // Configuration
  logic [2:0] prg_rom_size_log2;
  logic       chr_is_ram;

  // Mapper state
  sbsm_pkg::bank_regs_t regs;
  sbsm_pkg::bank_regs_t regs_next;
  logic [4:0] shift_bits;
  logic [4:0] shift_bits_next;
  logic [2:0] shift_count;
  logic [2:0] shift_count_next;
  logic       loaded_next;
  logic [4:0] shift_word;

  // Input register
  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [15:0] s1_address;
  logic [7:0]  s1_data;

  logic in_fire;
  logic advance;
  sbsm_pkg::xlate_result_t xlate;

  // Handshake: stage 1 moves on when the result register is free or draining
  assign advance  = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  sbsm_xlate #(
    .PRG_RAM_BYTES(PRG_RAM_BYTES)
  ) u_xlate (
    .cmd              (s1_cmd),
    .address          (s1_address),
    .regs             (regs),
    .prg_rom_size_log2(prg_rom_size_log2),
    .chr_is_ram       (chr_is_ram),
    .result           (xlate)
  );

  // Serial port next state
  assign shift_word = {s1_data[0], shift_bits[4:1]};
  always_comb begin
    regs_next        = regs;
    shift_bits_next  = shift_bits;
    shift_count_next = shift_count;
    loaded_next      = 1'b0;
    if (s1_cmd == sbsm_pkg::CMD_CPU_WRITE && s1_address[15]) begin
      if (s1_data[7]) begin
        shift_bits_next               = 5'd0;
        shift_count_next              = 3'd0;
        regs_next.control_word[3:2]   = 2'b11;
      end else if (shift_count == sbsm_pkg::SHIFT_LAST) begin
        shift_bits_next  = 5'd0;
        shift_count_next = 3'd0;
        loaded_next      = 1'b1;
        unique case (s1_address[14:13])
          2'd0:    regs_next.control_word  = shift_word;
          2'd1:    regs_next.chr_bank_low  = shift_word;
          2'd2:    regs_next.chr_bank_high = shift_word;
          default: regs_next.prg_bank      = shift_word[3:0];
        endcase
      end else begin
        shift_bits_next  = shift_word;
        shift_count_next = shift_count + 3'd1;
      end
    end
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_rom_size_log2 <= 3'd4;
      chr_is_ram        <= 1'b0;
      regs              <= '{control_word: 5'h0F, chr_bank_low: 5'd0,
                             chr_bank_high: 5'd0, prg_bank: 4'd0};
      shift_bits        <= 5'd0;
      shift_count       <= 3'd0;
    end else begin
      if (advance) begin
        regs        <= regs_next;
        shift_bits  <= shift_bits_next;
        shift_count <= shift_count_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          sbsm_pkg::CFG_PRG_ROM_SIZE_LOG2: prg_rom_size_log2 <= cfg_data;
          sbsm_pkg::CFG_CHR_IS_RAM:        chr_is_ram <= cfg_data[0];
          sbsm_pkg::CFG_HEADER_VERTICAL:
            regs.control_word <= {regs.control_word[4:2], 1'b1, ~cfg_data[0]};
          default: ;
        endcase
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd     <= cmd;
      s1_address <= address;
      s1_data    <= data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      region          <= xlate.region;
      mapped_address  <= xlate.mapped_address;
      write_allowed   <= xlate.write_allowed;
      register_loaded <= loaded_next;
    end
  end

  // Checks
  `SBSM_ASSERT_NOW(a_count_range, clk, rst, 1'b1, shift_count <= sbsm_pkg::SHIFT_LAST,
    "serial shift count beyond fifth bit")
  `SBSM_ASSERT_NEXT(a_advance_fills, clk, rst, advance, out_valid,
    "result register empty after a transaction moved in")
  `SBSM_ASSERT_NOW(a_load_on_rom, clk, rst, out_valid && register_loaded,
    region == sbsm_pkg::REGION_PRG_ROM, "register load reported outside PRG ROM")
  `SBSM_ASSERT_NOW(a_rom_readonly, clk, rst, out_valid && region == sbsm_pkg::REGION_PRG_ROM,
    !write_allowed, "PRG ROM reported writable")
  `SBSM_ASSERT_NEXT(a_serial_reset, clk, rst,
    advance && s1_cmd == sbsm_pkg::CMD_CPU_WRITE && s1_address[15] && s1_data[7],
    regs.control_word[3:2] == 2'b11 && shift_count == 3'd0, "serial reset not applied")

endmodule

`default_nettype wire

// ===== sv/sbsm_xlate.sv =====
`default_nettype none

// Address translation of one access against the current bank registers
module sbsm_xlate #(
  parameter int PRG_RAM_BYTES = 2048
) (
  input  wire logic [1:0]           cmd,
  input  wire logic [15:0]          address,
  input  wire sbsm_pkg::bank_regs_t regs,
  input  wire logic [2:0]           prg_rom_size_log2,
  input  wire logic                 chr_is_ram,
  output sbsm_pkg::xlate_result_t   result
);

  localparam logic [14:0] RamOnce  = 15'(PRG_RAM_BYTES);
  localparam logic [14:0] RamTwice = 15'(2 * PRG_RAM_BYTES);

  logic [1:0]  prg_mode;
  logic        prg_upper;
  logic [3:0]  prg_sel;
  logic [2:0]  prg_lg;
  logic [3:0]  prg_eff;
  logic [14:0] ram_x0;
  logic [14:0] ram_x1;
  logic [14:0] ram_x2;
  logic [13:0] ppu_addr;
  logic [4:0]  chr_sel;
  logic        nt_table;

  // PRG ROM bank selection by mode
  assign prg_mode  = regs.control_word[3:2];
  assign prg_upper = address[14];
  always_comb begin
    unique case (prg_mode)
      2'd0, 2'd1: prg_sel = {regs.prg_bank[3:1], prg_upper};
      2'd2:       prg_sel = prg_upper ? regs.prg_bank : 4'd0;
      default:    prg_sel = prg_upper ? 4'hF : regs.prg_bank;
    endcase
  end

  // Wrap bank number to the ROM size (sizes above 16 banks clamp)
  assign prg_lg = (prg_rom_size_log2 > 3'd4) ? 3'd4 : prg_rom_size_log2;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prg_eff[i] = prg_sel[i] & (prg_lg > 3'(i));
    end
  end

  // PRG RAM offset mod size; offset is below four times the size
  assign ram_x0 = {2'b00, address[12:0]};
  assign ram_x1 = (ram_x0 >= RamTwice) ? (ram_x0 - RamTwice) : ram_x0;
  assign ram_x2 = (ram_x1 >= RamOnce) ? (ram_x1 - RamOnce) : ram_x1;

  // CHR bank: one 8 KiB bank or two 4 KiB banks
  assign ppu_addr = address[13:0];
  always_comb begin
    if (!regs.control_word[4]) begin
      chr_sel = {regs.chr_bank_low[4:1], ppu_addr[12]};
    end else begin
      chr_sel = ppu_addr[12] ? regs.chr_bank_high : regs.chr_bank_low;
    end
  end

  // Nametable mirroring
  always_comb begin
    unique case (regs.control_word[1:0])
      2'd0:    nt_table = 1'b0;
      2'd1:    nt_table = 1'b1;
      2'd2:    nt_table = ppu_addr[10];
      default: nt_table = ppu_addr[11];
    endcase
  end

  // Region decode
  always_comb begin
    result = '{region: sbsm_pkg::REGION_NONE, mapped_address: 18'd0, write_allowed: 1'b0};
    unique case (cmd)
      sbsm_pkg::CMD_CPU_READ, sbsm_pkg::CMD_CPU_WRITE: begin
        if (address[15]) begin
          result.region         = sbsm_pkg::REGION_PRG_ROM;
          result.mapped_address = {prg_eff, address[13:0]};
        end else if (address[14:13] == 2'b11) begin
          result.region         = sbsm_pkg::REGION_PRG_RAM;
          result.mapped_address = {3'b000, ram_x2};
          result.write_allowed  = 1'b1;
        end
      end
      sbsm_pkg::CMD_PPU: begin
        if (!ppu_addr[13]) begin
          result.region         = sbsm_pkg::REGION_CHR;
          result.mapped_address = {1'b0, chr_sel, ppu_addr[11:0]};
          result.write_allowed  = chr_is_ram;
        end else if (!ppu_addr[12]) begin
          result.region         = sbsm_pkg::REGION_NAMETABLE;
          result.mapped_address = {7'd0, nt_table, ppu_addr[9:0]};
          result.write_allowed  = 1'b1;
        end else if (ppu_addr[11:8] == 4'hF) begin
          result.region         = sbsm_pkg::REGION_PALETTE;
          result.mapped_address = {13'd0, ppu_addr[4:0]};
          result.write_allowed  = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sim/sbsm_translation_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the mapper, predicts each translation from its own
// copy of the bank registers and compares results in order.
module sbsm_translation_checker #(
  parameter int PRG_RAM_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  region,
  input  logic [17:0] mapped_address,
  input  logic        write_allowed,
  input  logic        register_loaded,
  output int          pending_count,
  output int          mismatch_count
);

  // PRG banking modes held in control bits 3:2
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  // Nametable arrangement held in control bits 1:0
  localparam logic [1:0] MIRROR_ONE_LOW    = 2'd0;
  localparam logic [1:0] MIRROR_ONE_HIGH   = 2'd1;
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

  // Serial target picked by CPU address bits 14:13
  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;

  typedef struct packed {
    sbsm_pkg::region_t region;
    logic [17:0]       mapped_address;
    logic              write_allowed;
    logic              register_loaded;
  } translation_t;

  // configuration copy
  logic [2:0] prg_size_log2;
  logic       chr_ram;

  // bank state copy
  logic [4:0] shifter;
  logic [2:0] shift_len;
  logic [4:0] control;
  logic [4:0] chr_lo;
  logic [4:0] chr_hi;
  logic [3:0] prg_sel;

  translation_t expected_q[$];
  int           failures;

  // Translate one transaction with the banks as they stand, then apply any
  // serial write it carries.
  task automatic predict_translation(input logic [1:0] c, input logic [15:0] a,
                                     input logic [7:0] d, output translation_t t);
    logic [13:0] pa;
    logic [3:0]  bank4;
    logic [4:0]  bank5;
    logic        nt_sel;
    logic [2:0]  lg;
    logic [31:0] wide;
    t.region          = sbsm_pkg::REGION_NONE;
    t.mapped_address  = '0;
    t.write_allowed   = 1'b0;
    t.register_loaded = 1'b0;
    pa = a[13:0];
    case (c)
      sbsm_pkg::CMD_CPU_READ, sbsm_pkg::CMD_CPU_WRITE: begin
        if (a[15]) begin
          t.region = sbsm_pkg::REGION_PRG_ROM;
          lg = (prg_size_log2 > 3'd4) ? 3'd4 : prg_size_log2;
          case (control[3:2])
            PRG_MODE_FIX_FIRST: bank4 = a[14] ? prg_sel : 4'd0;
            PRG_MODE_FIX_LAST:  bank4 = a[14] ? 4'hF : prg_sel;
            default:            bank4 = {prg_sel[3:1], a[14]};
          endcase
          wide = {14'd0, bank4, a[13:0]} & ((32'h4000 << lg) - 32'd1);
          t.mapped_address = wide[17:0];
          // serial port: bit 7 clears, fifth bit loads
          if (c == sbsm_pkg::CMD_CPU_WRITE) begin
            if (d[7]) begin
              shifter      = '0;
              shift_len    = '0;
              control[3:2] = PRG_MODE_FIX_LAST;
            end else begin
              shifter   = {d[0], shifter[4:1]};
              shift_len = shift_len + 3'd1;
              if (shift_len == 3'd5) begin
                case (a[14:13])
                  SEL_CONTROL:  control = shifter;
                  SEL_CHR_LOW:  chr_lo  = shifter;
                  SEL_CHR_HIGH: chr_hi  = shifter;
                  default:      prg_sel = shifter[3:0];
                endcase
                shifter   = '0;
                shift_len = '0;
                t.register_loaded = 1'b1;
              end
            end
          end
        end else if (a >= 16'h6000) begin
          t.region = sbsm_pkg::REGION_PRG_RAM;
          wide = (a - 16'h6000) % PRG_RAM_BYTES;
          t.mapped_address = wide[17:0];
          t.write_allowed = 1'b1;
        end
      end
      sbsm_pkg::CMD_PPU: begin
        if (!pa[13]) begin
          t.region = sbsm_pkg::REGION_CHR;
          if (control[4]) bank5 = pa[12] ? chr_hi : chr_lo;
          else bank5 = {chr_lo[4:1], pa[12]};
          t.mapped_address = {1'b0, bank5, pa[11:0]};
          t.write_allowed = chr_ram;
        end else if (!pa[12]) begin
          t.region = sbsm_pkg::REGION_NAMETABLE;
          case (control[1:0])
            MIRROR_ONE_LOW:  nt_sel = 1'b0;
            MIRROR_ONE_HIGH: nt_sel = 1'b1;
            MIRROR_VERTICAL: nt_sel = pa[10];
            default:         nt_sel = pa[11];
          endcase
          t.mapped_address = {7'd0, nt_sel, pa[9:0]};
          t.write_allowed = 1'b1;
        end else if (pa[11:8] == 4'hF) begin
          t.region = sbsm_pkg::REGION_PALETTE;
          t.mapped_address = {13'd0, pa[4:0]};
          t.write_allowed = 1'b1;
        end
      end
      default: ;  // unused command: nothing mapped, state untouched
    endcase
  endtask

  always @(posedge clk) begin : track
    translation_t want;
    if (rst) begin
      prg_size_log2 = 3'd4;
      chr_ram       = 1'b0;
      shifter       = '0;
      shift_len     = '0;
      control       = {1'b0, PRG_MODE_FIX_LAST, MIRROR_HORIZONTAL};
      chr_lo        = '0;
      chr_hi        = '0;
      prg_sel       = '0;
      failures      = 0;
      expected_q.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          sbsm_pkg::CFG_PRG_ROM_SIZE_LOG2: prg_size_log2 = cfg_data;
          sbsm_pkg::CFG_CHR_IS_RAM:        chr_ram = cfg_data[0];
          sbsm_pkg::CFG_HEADER_VERTICAL:
            control[1:0] = cfg_data[0] ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
          default: ;
        endcase
      end
      // accepted transaction in
      if (in_valid && !in_stall) begin
        predict_translation(cmd, address, data, want);
        expected_q.push_back(want);
      end
      // accepted transaction out
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (failures < 10)
            $display("%0t: unexpected result region %0d addr %h wr %b ld %b", $time,
                     region, mapped_address, write_allowed, register_loaded);
          failures++;
        end else begin
          want = expected_q.pop_front();
          if (region !== want.region || mapped_address !== want.mapped_address ||
              write_allowed !== want.write_allowed ||
              register_loaded !== want.register_loaded) begin
            if (failures < 10)
              $display("%0t: mismatch exp region %0d addr %h wr %b ld %b, got %0d %h %b %b",
                       $time, want.region, want.mapped_address, want.write_allowed,
                       want.register_loaded, region, mapped_address, write_allowed,
                       register_loaded);
            failures++;
          end
        end
      end
    end
    pending_count  <= expected_q.size();
    mismatch_count <= failures;
  end

endmodule

// ===== sim/serial_bank_switch_mapper_unit_test.sv =====
`timescale 1ns / 1ps

module serial_bank_switch_mapper_unit_test;

  localparam int RAM_BYTES      = 2048;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASES         = 8;
  localparam int PHASE_ACCESSES = 230;
  localparam int HOLD_CYCLES    = 60;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [2:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [7:0]  data;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  region;
  logic [17:0] mapped_address;
  logic        write_allowed;
  logic        register_loaded;

  int pending_count;
  int mismatch_count;
  int access_count;
  int cycle_count;
  int hold_len;
  bit no_idle;

  serial_bank_switch_mapper_unit #(.PRG_RAM_BYTES(RAM_BYTES)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .address(address), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .region(region), .mapped_address(mapped_address),
    .write_allowed(write_allowed), .register_loaded(register_loaded)
  );

  sbsm_translation_checker #(.PRG_RAM_BYTES(RAM_BYTES)) translation_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .address(address), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .region(region), .mapped_address(mapped_address),
    .write_allowed(write_allowed), .register_loaded(register_loaded),
    .pending_count(pending_count), .mismatch_count(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[serial_bank_switch_mapper_unit] ERROR");
    $finish;
  end

  // Result side: random stall per transaction, plus the occasional long hold
  initial begin : take_results
    int gap;
    out_stall = 1'b0;
    forever begin
      if (hold_len != 0) begin
        out_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one transaction after a random gap; returns at the falling edge after
  // it was taken, with valid still high.
  task automatic offer(input logic [1:0] c, input logic [15:0] a, input logic [7:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd      = c;
    address  = a;
    data     = d;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    access_count++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic settle();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [2:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Any transaction that leaves the serial shifter alone
  task automatic offer_bystander();
    logic [15:0] a;
    logic [7:0]  d;
    a = 16'($urandom);
    d = 8'($urandom);
    case ($urandom_range(0, 3))
      0: offer(sbsm_pkg::CMD_CPU_READ, a, d);
      1: offer(sbsm_pkg::CMD_PPU, a, d);
      2: begin
        a[15] = 1'b0;
        offer(sbsm_pkg::CMD_CPU_WRITE, a, d);
      end
      default: offer(CMD_UNUSED, a, d);
    endcase
  endtask

  // Random transaction, steered towards the interesting address windows
  task automatic offer_noise();
    logic [1:0]  c;
    logic [15:0] a;
    logic [7:0]  d;
    a = 16'($urandom);
    d = 8'($urandom);
    if ($urandom_range(0, 31) == 0) c = CMD_UNUSED;
    else case ($urandom_range(0, 2))
      0: c = sbsm_pkg::CMD_CPU_READ;
      1: c = sbsm_pkg::CMD_CPU_WRITE;
      default: c = sbsm_pkg::CMD_PPU;
    endcase
    if (c == sbsm_pkg::CMD_PPU) begin
      case ($urandom_range(0, 4))
        0: a[13] = 1'b0;
        1: a[13:12] = 2'b10;
        2: a[13:8] = 6'h3F;
        3: a[13:12] = 2'b11;
        default: ;
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: a[15:13] = 3'b011;
        1: a[15] = 1'b1;
        2: a[15] = 1'b0;
        default: ;
      endcase
    end
    offer(c, a, d);
  endtask

  // Serial load of one bank register, LSB first, with bystanders mixed in.
  // Fewer than five bits leaves the shifter part-filled.
  task automatic load_register(input logic [1:0] sel, input logic [4:0] value, input int bits);
    logic [15:0] a;
    logic [7:0]  d;
    if ($urandom_range(0, 1) != 0) begin
      a = 16'($urandom);
      d = 8'($urandom);
      a[15] = 1'b1;
      d[7]  = 1'b1;
      offer(sbsm_pkg::CMD_CPU_WRITE, a, d);
    end
    for (int k = 0; k < bits; k++) begin
      if ($urandom_range(0, 3) == 0) offer_bystander();
      a = 16'($urandom);
      d = 8'($urandom);
      a[15:13] = {1'b1, sel};
      d[7]     = 1'b0;
      d[0]     = value[k];
      offer(sbsm_pkg::CMD_CPU_WRITE, a, d);
    end
  endtask

  initial begin : stimulus
    int first;
    int pick;
    logic [2:0] size_sel;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    cmd       = sbsm_pkg::CMD_CPU_READ;
    address   = '0;
    data      = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: window edges, every command, serial reset and a full PRG load
    offer(sbsm_pkg::CMD_CPU_READ,  16'h0000, 8'hFF);
    offer(sbsm_pkg::CMD_CPU_READ,  16'h5FFF, 8'h00);
    offer(sbsm_pkg::CMD_CPU_READ,  16'h6000, 8'h00);
    offer(sbsm_pkg::CMD_CPU_WRITE, 16'h7FFF, 8'hFF);
    offer(sbsm_pkg::CMD_CPU_READ,  16'h8000, 8'h00);
    offer(sbsm_pkg::CMD_CPU_READ,  16'hBFFF, 8'h00);
    offer(sbsm_pkg::CMD_CPU_READ,  16'hC000, 8'h00);
    offer(sbsm_pkg::CMD_CPU_READ,  16'hFFFF, 8'h00);
    offer(sbsm_pkg::CMD_PPU,       16'h0000, 8'h00);
    offer(sbsm_pkg::CMD_PPU,       16'h1FFF, 8'h00);
    offer(sbsm_pkg::CMD_PPU,       16'h2000, 8'h00);
    offer(sbsm_pkg::CMD_PPU,       16'h2FFF, 8'h00);
    offer(sbsm_pkg::CMD_PPU,       16'h3000, 8'h00);
    offer(sbsm_pkg::CMD_PPU,       16'h3EFF, 8'h00);
    offer(sbsm_pkg::CMD_PPU,       16'h3F00, 8'h00);
    offer(sbsm_pkg::CMD_PPU,       16'hFFFF, 8'hFF);   // upper PPU bits ignored
    offer(CMD_UNUSED,              16'hFFFF, 8'hFF);
    offer(sbsm_pkg::CMD_CPU_WRITE, 16'h8000, 8'h80);   // serial reset
    for (int k = 0; k < 5; k++)
      offer(sbsm_pkg::CMD_CPU_WRITE, 16'hE000, 8'h01); // PRG load, bit 4 dropped
    offer(sbsm_pkg::CMD_CPU_READ,  16'h8000, 8'h00);
    offer(sbsm_pkg::CMD_PPU,       16'h2400, 8'h00);

    // random phases, one register setting each
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      size_sel = 3'(phase);
      set_register(sbsm_pkg::CFG_PRG_ROM_SIZE_LOG2, size_sel);
      set_register(sbsm_pkg::CFG_CHR_IS_RAM, {2'b00, size_sel[0]});
      set_register(sbsm_pkg::CFG_HEADER_VERTICAL, {2'b00, size_sel[1]});
      no_idle = (phase == 2 || phase == 5);
      // long output hold while transactions keep coming, to fill the block
      if (phase == 2) hold_len = HOLD_CYCLES;
      first = access_count;
      while (access_count - first < PHASE_ACCESSES) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) load_register(2'($urandom_range(0, 3)), 5'($urandom), 5);
        else if (pick < 7)
          load_register(2'($urandom_range(0, 3)), 5'($urandom), $urandom_range(1, 4));
        else offer_noise();
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) $display("[serial_bank_switch_mapper_unit] OK");
    else $display("[serial_bank_switch_mapper_unit] ERROR");
    $finish;
  end

endmodule
